>>> sv/cantxq_pkg.sv
// shared constants, request codes and helpers of the can transmit queue
package cantxq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;

  localparam int unsigned ID_W   = 11;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned BYTES  = DATA_W / 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE  = 2'd0,
    REQ_PEEK   = 2'd1,
    REQ_COMMIT = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  // bytes at or above the length are zeroed, lengths of eight and above keep all
  function automatic logic [DATA_W-1:0] mask_data(input logic [LEN_W-1:0] len,
                                                  input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] res;
    res = data;
    for (int i = 0; i < BYTES; i++) begin
      if ({1'b0, len} <= (LEN_W+1)'(i)) begin
        res[i*8 +: 8] = 8'h00;
      end
    end
    return res;
  endfunction

endpackage

>>> sv/can_tx_message_queue_commit.sv
// can transmit message queue: ring of message slots with write, peek, commit and clear
//
// One request is taken per clock cycle (busy never rises). A request taken at a
// clock edge is registered and worked on in the next cycle. Its result is
// registered at the end of that cycle and appears on the result ports, marked
// by done, and stays for exactly one cycle. The receiver cannot stall it, so
// results must be taken as they appear.
// Every result shows the head message and the empty and full status after the
// request; head fields read zero while the queue is empty. The slot store is three
// arrays (id, length, data) written at the write pointer and read at the head pointer.
module can_tx_message_queue_commit #(
  parameter int unsigned QUEUE_DEPTH = cantxq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [cantxq_pkg::REQ_W-1:0]    req_type,
  input  logic [cantxq_pkg::ID_W-1:0]     msg_id,
  input  logic [cantxq_pkg::LEN_W-1:0]    msg_len,
  input  logic [cantxq_pkg::DATA_W-1:0]   msg_data,
  output logic                            done,
  output logic                            ok,
  output logic [cantxq_pkg::ID_W-1:0]     head_id,
  output logic [cantxq_pkg::LEN_W-1:0]    head_len,
  output logic [cantxq_pkg::DATA_W-1:0]   head_data,
  output logic                            is_empty,
  output logic                            is_full
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  // slot store
  logic [cantxq_pkg::ID_W-1:0]   slot_id   [QUEUE_DEPTH];
  logic [cantxq_pkg::LEN_W-1:0]  slot_len  [QUEUE_DEPTH];
  logic [cantxq_pkg::DATA_W-1:0] slot_data [QUEUE_DEPTH];

  // input register
  logic                          in_valid;
  cantxq_pkg::req_t              in_req;
  logic [cantxq_pkg::ID_W-1:0]   in_id;
  logic [cantxq_pkg::LEN_W-1:0]  in_len;
  logic [cantxq_pkg::DATA_W-1:0] in_data;

  // queue pointers
  logic [PTR_W-1:0] write_ptr, write_ptr_next;
  logic [PTR_W-1:0] read_ptr, read_ptr_next;
  logic             full_flag, full_flag_next;

  logic                          empty_now;
  logic                          empty_next;
  logic                          wr_en;
  logic                          ok_next;
  logic [cantxq_pkg::DATA_W-1:0] wr_data;
  logic [PTR_W-1:0]              wr_adv;
  logic [PTR_W-1:0]              rd_adv;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_req  <= cantxq_pkg::req_t'(req_type);
      in_id   <= msg_id;
      in_len  <= msg_len;
      in_data <= msg_data;
    end
  end

  assign empty_now = (read_ptr == write_ptr) && !full_flag;
  assign wr_adv    = (write_ptr == LAST_PTR) ? '0 : write_ptr + PTR_W'(1);
  assign rd_adv    = (read_ptr == LAST_PTR) ? '0 : read_ptr + PTR_W'(1);
  assign wr_data   = cantxq_pkg::mask_data(in_len, in_data);

  always_comb begin
    write_ptr_next = write_ptr;
    read_ptr_next  = read_ptr;
    full_flag_next = full_flag;
    wr_en          = 1'b0;
    ok_next        = 1'b0;
    if (in_valid) begin
      unique case (in_req)
        cantxq_pkg::REQ_WRITE: begin
          if (!full_flag) begin
            wr_en          = 1'b1;
            write_ptr_next = wr_adv;
            full_flag_next = (wr_adv == read_ptr);
            ok_next        = 1'b1;
          end
        end
        cantxq_pkg::REQ_PEEK: begin
          ok_next = !empty_now;
        end
        cantxq_pkg::REQ_COMMIT: begin
          if (!empty_now) begin
            read_ptr_next  = rd_adv;
            full_flag_next = 1'b0;
            ok_next        = 1'b1;
          end
        end
        cantxq_pkg::REQ_CLEAR: begin
          read_ptr_next  = '0;
          write_ptr_next = '0;
          full_flag_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign empty_next = (read_ptr_next == write_ptr_next) && !full_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
      full_flag <= 1'b0;
      done      <= 1'b0;
    end else begin
      write_ptr <= write_ptr_next;
      read_ptr  <= read_ptr_next;
      full_flag <= full_flag_next;
      done      <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_id[write_ptr]   <= in_id;
      slot_len[write_ptr]  <= in_len;
      slot_data[write_ptr] <= wr_data;
    end
  end

  // head read, with bypass when the new message becomes the head in this cycle
  always_ff @(posedge clk) begin
    if (in_valid) begin
      ok       <= ok_next;
      is_empty <= empty_next;
      is_full  <= full_flag_next;
      if (empty_next) begin
        head_id   <= '0;
        head_len  <= '0;
        head_data <= '0;
      end else if (wr_en && (write_ptr == read_ptr_next)) begin
        head_id   <= in_id;
        head_len  <= in_len;
        head_data <= wr_data;
      end else begin
        head_id   <= slot_id[read_ptr_next];
        head_len  <= slot_len[read_ptr_next];
        head_data <= slot_data[read_ptr_next];
      end
    end
  end

endmodule

>>> verif/tb_top.sv
// testbench for the can transmit queue: request driver, status predictor and result checker
package tb_queue_pkg;

  typedef struct {
    logic                          ok;
    logic [cantxq_pkg::ID_W-1:0]   id;
    logic [cantxq_pkg::LEN_W-1:0]  len;
    logic [cantxq_pkg::DATA_W-1:0] data;
    logic                          empty;
    logic                          full;
  } head_status_t;

  class queue_tracker;
    logic [cantxq_pkg::ID_W-1:0]   slot_id   [cantxq_pkg::QUEUE_DEPTH_DEFAULT];
    logic [cantxq_pkg::LEN_W-1:0]  slot_len  [cantxq_pkg::QUEUE_DEPTH_DEFAULT];
    logic [cantxq_pkg::DATA_W-1:0] slot_data [cantxq_pkg::QUEUE_DEPTH_DEFAULT];
    int unsigned       wr_ptr;
    int unsigned       rd_ptr;
    bit                full;
    head_status_t      pending_status [$];
    int                errs;

    function new();
      wr_ptr = 0;
      rd_ptr = 0;
      full   = 0;
      errs   = 0;
    endfunction

    function bit holds_nothing();
      return (wr_ptr == rd_ptr) && !full;
    endfunction

    function int outstanding();
      return pending_status.size();
    endfunction

    function void report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errs++;
    endfunction

    // work out the status the block should show after this request
    function void take_request(cantxq_pkg::req_t req, logic [cantxq_pkg::ID_W-1:0] id,
                               logic [cantxq_pkg::LEN_W-1:0] len,
                               logic [cantxq_pkg::DATA_W-1:0] data);
      head_status_t s;
      logic [cantxq_pkg::DATA_W-1:0] kept;
      s.ok = 1'b0;
      case (req)
        cantxq_pkg::REQ_WRITE: begin
          if (!full) begin
            kept = data;
            // bytes past the length are stored as zero
            for (int b = 0; b < cantxq_pkg::BYTES; b++) begin
              if (b >= len) kept[b*8 +: 8] = 8'h00;
            end
            slot_id[wr_ptr]   = id;
            slot_len[wr_ptr]  = len;
            slot_data[wr_ptr] = kept;
            wr_ptr = (wr_ptr + 1) % cantxq_pkg::QUEUE_DEPTH_DEFAULT;
            if (wr_ptr == rd_ptr) full = 1'b1;
            s.ok = 1'b1;
          end
        end
        cantxq_pkg::REQ_PEEK: s.ok = !holds_nothing();
        cantxq_pkg::REQ_COMMIT: begin
          if (!holds_nothing()) begin
            rd_ptr = (rd_ptr + 1) % cantxq_pkg::QUEUE_DEPTH_DEFAULT;
            full   = 1'b0;
            s.ok   = 1'b1;
          end
        end
        default: begin
          rd_ptr = 0;
          wr_ptr = 0;
          full   = 1'b0;
        end
      endcase
      if (holds_nothing()) begin
        s.id    = '0;
        s.len   = '0;
        s.data  = '0;
        s.empty = 1'b1;
      end else begin
        s.id    = slot_id[rd_ptr];
        s.len   = slot_len[rd_ptr];
        s.data  = slot_data[rd_ptr];
        s.empty = 1'b0;
      end
      s.full = full;
      pending_status.push_back(s);
    endfunction

    function void compare_field(string name, logic [cantxq_pkg::DATA_W-1:0] got,
                                logic [cantxq_pkg::DATA_W-1:0] want);
      if (got !== want) report($sformatf("%s got %0h, expected %0h", name, got, want));
    endfunction

    function void match_status(head_status_t got);
      head_status_t want;
      if (pending_status.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = pending_status.pop_front();
      compare_field("ok", got.ok, want.ok);
      compare_field("head_id", got.id, want.id);
      compare_field("head_len", got.len, want.len);
      compare_field("head_data", got.data, want.data);
      compare_field("is_empty", got.empty, want.empty);
      compare_field("is_full", got.full, want.full);
    endfunction
  endclass
endpackage

module tb_top;

  localparam int STALL_LIMIT = 500;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [cantxq_pkg::REQ_W-1:0]  req_type;
  logic [cantxq_pkg::ID_W-1:0]   msg_id;
  logic [cantxq_pkg::LEN_W-1:0]  msg_len;
  logic [cantxq_pkg::DATA_W-1:0] msg_data;
  logic                          done;
  logic                          ok;
  logic [cantxq_pkg::ID_W-1:0]   head_id;
  logic [cantxq_pkg::LEN_W-1:0]  head_len;
  logic [cantxq_pkg::DATA_W-1:0] head_data;
  logic                          is_empty;
  logic                          is_full;

  tb_queue_pkg::queue_tracker tracker = new();
  bit gaps_on = 1'b1;
  int stall_cnt = 0;

  can_tx_message_queue_commit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .msg_id(msg_id), .msg_len(msg_len), .msg_data(msg_data),
    .done(done), .ok(ok), .head_id(head_id), .head_len(head_len), .head_data(head_data),
    .is_empty(is_empty), .is_full(is_full)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // results are checked before the request of the same edge is noted
  always @(posedge clk) begin
    tb_queue_pkg::head_status_t got;
    if (!rst) begin
      if (done === 1'b1) begin
        got.ok    = ok;
        got.id    = head_id;
        got.len   = head_len;
        got.data  = head_data;
        got.empty = is_empty;
        got.full  = is_full;
        tracker.match_status(got);
      end
      if (start && !busy) begin
        tracker.take_request(cantxq_pkg::req_t'(req_type), msg_id, msg_len, msg_data);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done === 1'b1) begin
        stall_cnt <= 0;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
      if (stall_cnt >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic issue_request(cantxq_pkg::req_t r, logic [cantxq_pkg::ID_W-1:0] id,
                               logic [cantxq_pkg::LEN_W-1:0] len,
                               logic [cantxq_pkg::DATA_W-1:0] data);
    if (gaps_on && $urandom_range(99) < 12) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start    <= 1'b1;
    req_type <= r;
    msg_id   <= id;
    msg_len  <= len;
    msg_data <= data;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_queue();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
  endtask

  function automatic logic [cantxq_pkg::LEN_W-1:0] pick_len();
    // mostly legal lengths, now and then one above eight
    if ($urandom_range(9) == 0) return cantxq_pkg::LEN_W'($urandom_range(9, 15));
    return cantxq_pkg::LEN_W'($urandom_range(0, 8));
  endfunction

  initial begin
    cantxq_pkg::req_t r;
    int   bias;
    int   burst;
    int   roll;
    rst      = 1'b1;
    start    = 1'b0;
    req_type = '0;
    msg_id   = '0;
    msg_len  = '0;
    msg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty queue: peek, commit and clear all see nothing
    issue_request(cantxq_pkg::REQ_PEEK, '0, '0, '0);
    issue_request(cantxq_pkg::REQ_COMMIT, '1, '1, '1);
    issue_request(cantxq_pkg::REQ_CLEAR, '0, '0, '0);
    // fill to the brim with every length, extreme identifiers at the ends
    for (int i = 0; i < cantxq_pkg::QUEUE_DEPTH_DEFAULT; i++) begin
      issue_request(cantxq_pkg::REQ_WRITE,
                    (i == 0) ? '0 :
                    (i == cantxq_pkg::QUEUE_DEPTH_DEFAULT - 1) ? '1 :
                    cantxq_pkg::ID_W'($urandom),
                    cantxq_pkg::LEN_W'(i), (i % 2) ? '1 : {$urandom, $urandom});
    end
    // dropped when full
    issue_request(cantxq_pkg::REQ_WRITE, 11'h155, 4'd8, {$urandom, $urandom});
    issue_request(cantxq_pkg::REQ_PEEK, '0, '0, '0);
    issue_request(cantxq_pkg::REQ_COMMIT, '0, '0, '0);
    issue_request(cantxq_pkg::REQ_WRITE, 11'h2aa, 4'd8, '1);  // refills the freed slot, so the queue is full again
    issue_request(cantxq_pkg::REQ_CLEAR, '0, '0, '0);
    drain_queue();

    // bursts that lean towards filling or draining so both ends are reached often
    bias  = 70;
    burst = 0;
    for (int n = 0; n < 550; n++) begin
      gaps_on = !(n >= 200 && n < 330);
      if (n == 400) drain_queue();
      if (burst == 0) begin
        burst = $urandom_range(10, 40);
        bias  = (bias > 50) ? $urandom_range(15, 35) : $urandom_range(65, 85);
      end
      burst--;
      roll = $urandom_range(99);
      if (roll < 2) r = cantxq_pkg::REQ_CLEAR;
      else if (roll < 12) r = cantxq_pkg::REQ_PEEK;
      else if (roll < 12 + (bias * 88) / 100) r = cantxq_pkg::REQ_WRITE;
      else r = cantxq_pkg::REQ_COMMIT;
      issue_request(r, cantxq_pkg::ID_W'($urandom), pick_len(), {$urandom, $urandom});
    end
    drain_queue();
    repeat (8) @(posedge clk);

    if (tracker.errs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

>>> files.f
sv/cantxq_pkg.sv
sv/can_tx_message_queue_commit.sv
verif/tb_top.sv
